@@ hw/rtl/cpmd_pkg.sv @@
// cpmd_pkg: shared types, widths, status codes and the microcode rom
// for the closest pair minimum distance unit
// no dependencies
package cpmd_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS     = 16;
    localparam int POINT_W        = 2 * COORD_BITS;
    localparam int DIFF_W         = COORD_BITS + 1;
    localparam int SQ_W           = 2 * DIFF_W;
    localparam int SUM_W          = SQ_W + 1;
    localparam int DIST_W         = 33;
    localparam int STATUS_W       = 2;
    localparam int OUT_DATA_W     = ((DIST_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FEW      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_START  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SCAN   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DRAIN0 = 3'd3;
    localparam logic [STEP_W-1:0] STEP_DRAIN1 = 3'd4;
    localparam logic [STEP_W-1:0] STEP_DRAIN2 = 3'd5;
    localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd6;

    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_ALWAYS      = 3'd0;
    localparam logic [COND_W-1:0] COND_ACCEPT_LAST = 3'd1;
    localparam logic [COND_W-1:0] COND_FEW         = 3'd2;
    localparam logic [COND_W-1:0] COND_LAST_PAIR   = 3'd3;
    localparam logic [COND_W-1:0] COND_OUT_FREE    = 3'd4;

    typedef struct packed {
        logic in_ready;
        logic ptr_clear;
        logic issue;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        ctrl_t             ctrl;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] tgt_true;
        logic [STEP_W-1:0] tgt_false;
    } ucode_t;

    typedef struct packed {
        logic accept_last;
        logic few;
        logic last_pair;
        logic out_free;
    } cond_t;

    typedef struct packed {
        logic few;
        logic last_pair;
        logic overflow;
    } agu_flags_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '0;
        case (step)
            STEP_LOAD:
            begin
                w.ctrl.in_ready = 1'b1;
                w.cond          = COND_ACCEPT_LAST;
                w.tgt_true      = STEP_START;
                w.tgt_false     = STEP_LOAD;
            end
            STEP_START:
            begin
                w.ctrl.ptr_clear = 1'b1;
                w.cond           = COND_FEW;
                w.tgt_true       = STEP_EMIT;
                w.tgt_false      = STEP_SCAN;
            end
            STEP_SCAN:
            begin
                w.ctrl.issue = 1'b1;
                w.cond       = COND_LAST_PAIR;
                w.tgt_true   = STEP_DRAIN0;
                w.tgt_false  = STEP_SCAN;
            end
            STEP_DRAIN0:
            begin
                w.cond      = COND_ALWAYS;
                w.tgt_true  = STEP_DRAIN1;
                w.tgt_false = STEP_DRAIN1;
            end
            STEP_DRAIN1:
            begin
                w.cond      = COND_ALWAYS;
                w.tgt_true  = STEP_DRAIN2;
                w.tgt_false = STEP_DRAIN2;
            end
            STEP_DRAIN2:
            begin
                w.cond      = COND_ALWAYS;
                w.tgt_true  = STEP_EMIT;
                w.tgt_false = STEP_EMIT;
            end
            STEP_EMIT:
            begin
                w.ctrl.emit = 1'b1;
                w.cond      = COND_OUT_FREE;
                w.tgt_true  = STEP_LOAD;
                w.tgt_false = STEP_EMIT;
            end
            default:
            begin
                w.cond      = COND_ALWAYS;
                w.tgt_true  = STEP_LOAD;
                w.tgt_false = STEP_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

@@ hw/rtl/cpmd_seq.sv @@
// cpmd_seq: microcode step counter, rom lookup and jump condition select
// depends on cpmd_pkg
module cpmd_seq
    import cpmd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cond_t cond,
    output ctrl_t ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            word;
    logic              taken;

    always_comb
    begin
        word = ucode_rom(step_reg);
        case (word.cond)
            COND_ALWAYS:      taken = 1'b1;
            COND_ACCEPT_LAST: taken = cond.accept_last;
            COND_FEW:         taken = cond.few;
            COND_LAST_PAIR:   taken = cond.last_pair;
            COND_OUT_FREE:    taken = cond.out_free;
            default:          taken = 1'b1;
        endcase
        step_next = taken ? word.tgt_true : word.tgt_false;
        ctrl      = word.ctrl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

@@ hw/rtl/cpmd_agu.sv @@
// cpmd_agu: point count, overflow flag and pair pointers for the search
// depends on cpmd_pkg
module cpmd_agu
    import cpmd_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int ADDR_W     = $clog2(MAX_POINTS),
    parameter int CNT_W      = $clog2(MAX_POINTS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              ptr_clear,
    input  logic              issue,
    input  logic              emit_fire,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [ADDR_W-1:0] rd_addr_a,
    output logic [ADDR_W-1:0] rd_addr_b,
    output agu_flags_t        flags
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [ADDR_W-1:0] i_reg;
    logic [ADDR_W-1:0] i_next;
    logic [ADDR_W-1:0] j_reg;
    logic [ADDR_W-1:0] j_next;
    logic              full;
    logic              row_end;

    assign full    = (count_reg == CNT_MAX);
    assign row_end = (CNT_W'(j_reg) == count_reg - CNT_W'(1));

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        if (emit_fire)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (accept)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (ptr_clear)
        begin
            i_next = '0;
            j_next = ADDR_W'(1);
        end
        else if (issue)
        begin
            if (row_end)
            begin
                i_next = i_reg + ADDR_W'(1);
                j_next = i_reg + ADDR_W'(2);
            end
            else
            begin
                j_next = j_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    assign wr_en           = accept & ~full;
    assign wr_addr         = count_reg[ADDR_W-1:0];
    assign rd_addr_a       = i_reg;
    assign rd_addr_b       = j_reg;
    assign flags.few       = (count_reg < CNT_W'(2));
    assign flags.last_pair = (CNT_W'(i_reg) == count_reg - CNT_W'(2));
    assign flags.overflow  = ovf_reg;

endmodule

@@ hw/rtl/cpmd_store.sv @@
// cpmd_store: point memory, one write port and two registered read ports
// depends on cpmd_pkg
module cpmd_store
    import cpmd_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int ADDR_W     = $clog2(MAX_POINTS)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [POINT_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr_a,
    input  logic [ADDR_W-1:0]  rd_addr_b,
    output logic [POINT_W-1:0] rd_data_a,
    output logic [POINT_W-1:0] rd_data_b
);

    logic [POINT_W-1:0] mem [MAX_POINTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

@@ hw/rtl/cpmd_dist.sv @@
// cpmd_dist: pipelined squared distance of one pair and running minimum
// depends on cpmd_pkg
module cpmd_dist
    import cpmd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ptr_clear,
    input  logic               issue,
    input  logic [POINT_W-1:0] pt_a,
    input  logic [POINT_W-1:0] pt_b,
    output logic [SUM_W-1:0]   best
);

    logic [2:0]               vld_reg;
    logic [2:0]               vld_next;
    logic [DIFF_W-1:0]        dx_reg;
    logic [DIFF_W-1:0]        dy_reg;
    logic [SQ_W-1:0]          sqx_reg;
    logic [SQ_W-1:0]          sqy_reg;
    logic [SUM_W-1:0]         best_reg;
    logic [SUM_W-1:0]         best_next;
    logic signed [DIFF_W-1:0] xa;
    logic signed [DIFF_W-1:0] xb;
    logic signed [DIFF_W-1:0] ya;
    logic signed [DIFF_W-1:0] yb;
    logic signed [DIFF_W-1:0] ddx;
    logic signed [DIFF_W-1:0] ddy;
    logic [SUM_W-1:0]         sum;

    always_comb
    begin
        xa  = DIFF_W'($signed(pt_a[COORD_BITS-1:0]));
        xb  = DIFF_W'($signed(pt_b[COORD_BITS-1:0]));
        ya  = DIFF_W'($signed(pt_a[POINT_W-1:COORD_BITS]));
        yb  = DIFF_W'($signed(pt_b[POINT_W-1:COORD_BITS]));
        ddx = xa - xb;
        ddy = ya - yb;
        sum = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
        vld_next  = {vld_reg[1:0], issue};
        best_next = best_reg;
        if (ptr_clear)
        begin
            best_next = '1;
        end
        else if (vld_reg[2] && (sum < best_reg))
        begin
            best_next = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            best_reg <= '1;
        end
        else
        begin
            vld_reg  <= vld_next;
            best_reg <= best_next;
        end
    end

    // abs difference, then squares
    always_ff @(posedge clk)
    begin
        dx_reg  <= ddx[DIFF_W-1] ? DIFF_W'(-ddx) : DIFF_W'(ddx);
        dy_reg  <= ddy[DIFF_W-1] ? DIFF_W'(-ddy) : DIFF_W'(ddy);
        sqx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
    end

    assign best = best_reg;

endmodule

@@ hw/rtl/closest_pair_min_distance_unit.sv @@
// closest_pair_min_distance_unit: top level, output register and wiring
// depends on cpmd_pkg, cpmd_seq, cpmd_agu, cpmd_store, cpmd_dist
// points load one per cycle in the load step; the last point starts a search of
// all pairs of the n stored points, one pair read per cycle via the two read ports
// the result passes the drain steps and emit; with n < 2 the search is skipped
// no point is taken during the search; the next set loads while a result waits
// rst_n clears control, counts and the output valid; point memory is not cleared
module closest_pair_min_distance_unit
    import cpmd_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [POINT_W-1:0]    s_tdata,   // px, py
    input  logic                  s_tlast,   // last_point
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // min_dist_sq, zero fill
    output logic [STATUS_W-1:0]   m_tuser    // status
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam logic [SUM_W-1:0] OUT_MAX = SUM_W'({DIST_W{1'b1}});

    ctrl_t              ctrl;
    cond_t              cond;
    agu_flags_t         flags;
    logic               accept;
    logic               out_free;
    logic               emit_fire;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr_a;
    logic [ADDR_W-1:0]  rd_addr_b;
    logic [POINT_W-1:0] rd_data_a;
    logic [POINT_W-1:0] rd_data_b;
    logic [SUM_W-1:0]   best;
    logic [DIST_W-1:0]  dist_res;
    logic [STATUS_W-1:0] status_res;

    logic                m_valid_reg;
    logic                m_valid_next;
    logic [DIST_W-1:0]   m_dist_reg;
    logic [STATUS_W-1:0] m_status_reg;

    assign s_tready  = ctrl.in_ready;
    assign accept    = s_tvalid & ctrl.in_ready;
    assign out_free  = ~m_valid_reg | m_tready;
    assign emit_fire = ctrl.emit & out_free;

    assign cond.accept_last = accept & s_tlast;
    assign cond.few         = flags.few;
    assign cond.last_pair   = flags.last_pair;
    assign cond.out_free    = out_free;

    cpmd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    cpmd_agu #(
        .MAX_POINTS (MAX_POINTS),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_agu (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ptr_clear (ctrl.ptr_clear),
        .issue     (ctrl.issue),
        .emit_fire (emit_fire),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .flags     (flags)
    );

    cpmd_store #(
        .MAX_POINTS (MAX_POINTS),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (s_tdata),
        .rd_en     (ctrl.issue),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    cpmd_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .ptr_clear (ctrl.ptr_clear),
        .issue     (ctrl.issue),
        .pt_a      (rd_data_a),
        .pt_b      (rd_data_b),
        .best      (best)
    );

    always_comb
    begin
        if (flags.few)
        begin
            dist_res   = '0;
            status_res = STATUS_FEW;
        end
        else
        begin
            dist_res   = (best > OUT_MAX) ? {DIST_W{1'b1}} : best[DIST_W-1:0];
            status_res = flags.overflow ? STATUS_OVERFLOW : STATUS_OK;
        end
        m_valid_next = m_valid_reg;
        if (emit_fire)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            m_dist_reg   <= dist_res;
            m_status_reg <= status_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'(m_dist_reg);
    assign m_tuser  = m_status_reg;

endmodule

@@ sim/cpmd_checker.sv @@
// cpmd_checker: watches the point and result streams of the closest pair unit,
// predicts each set's minimum squared distance and status, and counts mismatches
// depends on cpmd_pkg
module cpmd_checker
    import cpmd_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [POINT_W-1:0]    s_tdata,   // px, py
    input  logic                  s_tlast,   // last_point
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // min_dist_sq, zero fill
    input  logic [STATUS_W-1:0]   m_tuser,   // status
    output int                    errors,
    output int                    pending,
    output int                    results_seen
);

    localparam longint unsigned DIST_SAT = (64'd1 << DIST_W) - 64'd1;

    typedef struct packed {
        logic [DIST_W-1:0]   dist_sq;
        logic [STATUS_W-1:0] status;
    } set_result_t;

    set_result_t expected_dist_q[$];

    logic signed [COORD_BITS-1:0] set_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] set_y [MAX_POINTS];
    int unsigned                  set_size;
    bit                           set_dropped;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    // exhaustive search over all stored pairs
    function automatic logic [DIST_W-1:0] nearest_pair_dist(input int unsigned n);
        longint unsigned best;
        longint unsigned d;
        longint          dx;
        longint          dy;
        best = '1;
        for (int i = 0; i < n; i++)
        begin
            for (int j = i + 1; j < n; j++)
            begin
                dx = longint'(set_x[i]) - longint'(set_x[j]);
                dy = longint'(set_y[i]) - longint'(set_y[j]);
                if (dx < 0)
                    dx = -dx;
                if (dy < 0)
                    dy = -dy;
                d = longint'(dx * dx) + longint'(dy * dy);
                if (d < best)
                    best = d;
            end
        end
        if (best > DIST_SAT)
            best = DIST_SAT;
        return best[DIST_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        set_result_t want;
        if (!rst_n)
        begin
            set_size     = 0;
            set_dropped  = 0;
            expected_dist_q.delete();
            pending      = 0;
            errors       = 0;
            results_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_dist_q.size() == 0)
                    report_mismatch($sformatf("result %0d/%0d with no set pending",
                                              m_tdata, m_tuser));
                else
                begin
                    want = expected_dist_q.pop_front();
                    if (m_tdata !== OUT_DATA_W'(want.dist_sq))
                        report_mismatch($sformatf("min_dist_sq got %0d expected %0d",
                                                  m_tdata, want.dist_sq));
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  m_tuser, want.status));
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (set_size < MAX_POINTS)
                begin
                    set_x[set_size] = s_tdata[COORD_BITS-1:0];
                    set_y[set_size] = s_tdata[POINT_W-1:COORD_BITS];
                    set_size++;
                end
                else
                    set_dropped = 1;
                if (s_tlast)
                begin
                    if (set_size < 2)
                    begin
                        want.dist_sq = '0;
                        want.status  = STATUS_FEW;
                    end
                    else
                    begin
                        want.dist_sq = nearest_pair_dist(set_size);
                        want.status  = set_dropped ? STATUS_OVERFLOW : STATUS_OK;
                    end
                    expected_dist_q.push_back(want);
                    set_size    = 0;
                    set_dropped = 0;
                end
            end
            pending = expected_dist_q.size();
        end
    end

endmodule

@@ sim/tb.sv @@
// tb: point set stimulus and verdict for closest_pair_min_distance_unit
// depends on cpmd_pkg, the unit's rtl and cpmd_checker
module tb;
    import cpmd_pkg::*;

    localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] CMAX = ~CMIN;

    localparam int SPREAD_FULL  = 0;
    localparam int SPREAD_TIGHT = 1;
    localparam int SPREAD_EDGE  = 2;
    localparam int SPREAD_MIX   = 3;

    localparam int READY_ALWAYS = 0;
    localparam int READY_COIN   = 1;
    localparam int READY_SPARSE = 2;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [POINT_W-1:0]    s_tdata  = '0;   // px, py
    logic                  s_tlast  = 1'b0; // last_point
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // min_dist_sq, zero fill
    logic [STATUS_W-1:0]   m_tuser;         // status

    int errors;
    int pending;
    int results_seen;
    int burst_left  = 0;
    int points_sent = 0;
    int sets_sent   = 0;
    int ready_mode  = READY_ALWAYS;
    int ready_left  = 0;

    closest_pair_min_distance_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cpmd_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    // longest run is one full store search
    initial
    begin
        #30000000;
        $display("timeout with %0d results outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // result side stalls in stretches of changing style
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode <= $urandom_range(READY_ALWAYS, READY_SPARSE);
            ready_left <= $urandom_range(8, 80);
        end
        else
            ready_left <= ready_left - 1;
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            default:      m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic logic [COORD_BITS-1:0] pick_coord(input int spread);
        int sel;
        sel = (spread == SPREAD_MIX) ? $urandom_range(SPREAD_FULL, SPREAD_EDGE) : spread;
        case (sel)
            SPREAD_FULL:
                return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
            SPREAD_TIGHT:
                return COORD_BITS'(int'($urandom_range(0, 16)) - 8);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return CMIN;
                    1:       return CMIN + 1'b1;
                    2:       return CMAX;
                    default: return CMAX - 1'b1;
                endcase
            end
        endcase
    endfunction

    // one point transfer, with a random gap at the start of each burst
    task automatic push_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                              input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        points_sent++;
        if (last)
            sets_sent++;
    endtask

    task automatic push_set(input int n, input int spread);
        for (int i = 0; i < n; i++)
            push_point(pick_coord(spread), pick_coord(spread), i == n - 1);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int kind;
        int size;
        int start_pts;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone points, opposite corners, duplicates and a plain triangle
        push_point(CMIN, CMAX, 1'b1);
        push_point(CMIN, CMIN, 1'b0);
        push_point(CMAX, CMAX, 1'b1);
        push_point(CMAX, CMIN, 1'b0);
        push_point(CMIN, CMAX, 1'b1);
        push_point(16'd5, 16'd5, 1'b0);
        push_point(16'd100, -16'sd3, 1'b0);
        push_point(16'd5, 16'd5, 1'b1);
        push_point(16'd0, 16'd0, 1'b1);
        push_point(16'd0, 16'd0, 1'b0);
        push_point(16'd3, 16'd4, 1'b0);
        push_point(16'd10, 16'd10, 1'b1);
        push_point(-16'sd1, -16'sd1, 1'b0);
        push_point(16'd0, 16'd1, 1'b0);
        push_point(16'd0, 16'd0, 1'b1);
        drain_results();

        // store filled to capacity and past it
        push_set(MAX_POINTS_DEF + 3, SPREAD_MIX);
        drain_results();

        start_pts = points_sent;
        while (points_sent - start_pts < 500)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 8)
                size = 1;
            else if (kind < 70)
                size = $urandom_range(2, 8);
            else if (kind < 95)
                size = $urandom_range(9, 20);
            else
                size = $urandom_range(21, 48);
            push_set(size, $urandom_range(SPREAD_FULL, SPREAD_MIX));
        end
        drain_results();
        repeat (20) @(posedge clk);

        $display("covered %0d points in %0d sets, one set past store capacity",
                 points_sent, sets_sent);
        $display("compared %0d results, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ closest_pair_min_distance_unit.f @@
hw/rtl/cpmd_pkg.sv
hw/rtl/cpmd_seq.sv
hw/rtl/cpmd_agu.sv
hw/rtl/cpmd_store.sv
hw/rtl/cpmd_dist.sv
hw/rtl/closest_pair_min_distance_unit.sv
sim/cpmd_checker.sv
sim/tb.sv
